### src/fdg_pkg.sv
`default_nettype none
package fdg_pkg;

	// register map: bit 2 of paddr picks the register
	localparam logic REG_LIFT_SLOPE = 1'b0;
	localparam logic REG_MAX_DEFL   = 1'b1;

	localparam logic [15:0] LIFT_SLOPE_RST = 16'd1024;
	localparam logic [14:0] MAX_DEFL_RST   = 15'd5120;

	// degrees Q8.8 to radians Q2.14, scaled by 2^24
	localparam logic [24:0] DEG_TO_Q14 = 25'd18740330;
	localparam logic [39:0] DEG_RND    = 40'd8388608;
	localparam logic [15:0] ANGLE_MAX  = 16'd32767;

	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
	localparam logic [61:0] Q30_RND = 62'd536870912;

	localparam logic [63:0] SPEED_MIN_SQ = 64'd4294967296;
	localparam logic [31:0] PRESS_MIN    = 32'd26;
	localparam logic [47:0] LIFT_MIN     = 48'd6553600;
	localparam logic [13:0] ANGLE_SCALE  = 14'd10000;

	localparam int SQRT_STEPS = 32;
	localparam int AXIS_QW    = 31;
	localparam int ANG_QW     = 15;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic [31:0]        q;
		logic               vert;
		logic               inact;
	} fdg_ctx_t;

	typedef struct packed {
		logic ovf_p;
		logic ovf_y;
		logic neg_p;
		logic neg_y;
		logic lift_low;
		logic inact;
	} fdg_fin_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic signed [31:0] sgn31(input logic neg, input logic [30:0] m);
		logic signed [31:0] p;
		p = signed'({1'b0, m});
		return neg ? -p : p;
	endfunction

endpackage
`default_nettype wire

### src/fdg_isqrt.sv
`default_nettype none
// pipelined floor square root, one result bit per stage
module fdg_isqrt import fdg_pkg::*; #(
	parameter int LANES = 2,
	parameter int SW    = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [63:0]   in_x [LANES],
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [31:0]   out_root [LANES],
	output logic [SW-1:0] out_side
);

	logic          v_s    [SQRT_STEPS];
	logic [SW-1:0] side_s [SQRT_STEPS];
	logic [63:0]   x_s    [SQRT_STEPS][LANES];
	logic [63:0]   r_s    [SQRT_STEPS][LANES];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
		logic          vi;
		logic [SW-1:0] si;

		if (k == 0) begin : g_first
			assign vi = in_valid;
			assign si = in_side;
		end else begin : g_next
			assign vi = v_s[k-1];
			assign si = side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= si;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [63:0] xi;
			logic [63:0] ri;
			logic [64:0] trial;

			if (k == 0) begin : g_first
				assign xi = in_x[l];
				assign ri = '0;
			end else begin : g_next
				assign xi = x_s[k-1][l];
				assign ri = r_s[k-1][l];
			end

			assign trial = {1'b0, ri} + {1'b0, BITV};

			always_ff @(posedge clk) begin
				if (en) begin
					if ({1'b0, xi} >= trial) begin
						x_s[k][l] <= xi - trial[63:0];
						r_s[k][l] <= (ri >> 1) + BITV;
					end else begin
						x_s[k][l] <= xi;
						r_s[k][l] <= ri >> 1;
					end
				end
			end
		end
	end

	assign out_valid = v_s[SQRT_STEPS-1];
	assign out_side  = side_s[SQRT_STEPS-1];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign out_root[l] = r_s[SQRT_STEPS-1][l][31:0];
	end

endmodule
`default_nettype wire

### src/fdg_div.sv
`default_nettype none
// pipelined restoring divider, one quotient bit per stage.
// Quotient is exact when num < den * 2^QW.
module fdg_div #(
	parameter int LANES = 1,
	parameter int NW    = 62,
	parameter int DW    = 32,
	parameter int QW    = 31,
	parameter int SW    = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num [LANES],
	input  logic [DW-1:0] in_den [LANES],
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_quo [LANES],
	output logic [SW-1:0] out_side
);

	logic          v_s    [QW];
	logic [SW-1:0] side_s [QW];
	logic [NW-1:0] n_s    [QW][LANES];
	logic [DW-1:0] d_s    [QW][LANES];
	logic [DW-1:0] rem_s  [QW][LANES];
	logic [QW-1:0] q_s    [QW][LANES];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic          vi;
		logic [SW-1:0] si;

		if (k == 0) begin : g_first
			assign vi = in_valid;
			assign si = in_side;
		end else begin : g_next
			assign vi = v_s[k-1];
			assign si = side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= si;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [NW-1:0] ni;
			logic [DW-1:0] di;
			logic [DW-1:0] ri;
			logic [QW-1:0] qi;
			logic [DW:0]   t;
			logic [DW:0]   diff;
			logic          ge;

			if (k == 0) begin : g_first
				assign ni = in_num[l];
				assign di = in_den[l];
				assign ri = DW'(in_num[l] >> QW);
				assign qi = '0;
			end else begin : g_next
				assign ni = n_s[k-1][l];
				assign di = d_s[k-1][l];
				assign ri = rem_s[k-1][l];
				assign qi = q_s[k-1][l];
			end

			assign t    = {ri, ni[QW-1-k]};
			assign ge   = t >= {1'b0, di};
			assign diff = t - {1'b0, di};

			always_ff @(posedge clk) begin
				if (en) begin
					n_s[k][l]   <= ni;
					d_s[k][l]   <= di;
					rem_s[k][l] <= ge ? diff[DW-1:0] : t[DW-1:0];
					q_s[k][l]   <= {qi[QW-2:0], ge};
				end
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_side  = side_s[QW-1];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign out_quo[l] = q_s[QW-1][l];
	end

endmodule
`default_nettype wire

### src/fin_deflection_from_guidance.sv
`default_nettype none
// Fin deflection from guidance. Each input word carries acceleration and
// velocity (Q16.16) and dynamic pressure (Q24.8); each output word gives pitch
// and yaw fin angles (Q2.14 rad) and an inactive flag. One word is accepted
// per clock unless stalled; results pass through the 32-stage square root, the
// 31-stage axis divider and the 15-stage angle divider in series. A two-word
// output buffer keeps the input open while a result waits; the pipeline stalls
// only when that buffer is full. Registers: lift_slope at 0x0, max deflection
// (degrees Q8.8) at 0x4; write them only while no word is in flight.
module fin_deflection_from_guidance import fdg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// accel_x, accel_y, accel_z, vel_x, vel_y, vel_z, dyn_pressure
	input  logic [223:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pitch_angle, yaw_angle
	output logic [31:0]  m_axis_tdata,
	// inactive
	output logic         m_axis_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	// ---------------- config ----------------
	logic [15:0] slope_q;
	logic [14:0] maxdeg_q;
	logic [14:0] lim_q;
	logic [39:0] lim_prod;
	logic [15:0] lim_raw;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q  <= LIFT_SLOPE_RST;
			maxdeg_q <= MAX_DEFL_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_LIFT_SLOPE: slope_q  <= pwdata[15:0];
				REG_MAX_DEFL:   maxdeg_q <= pwdata[14:0];
				default:        slope_q  <= slope_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LIFT_SLOPE: prdata = {16'd0, slope_q};
			REG_MAX_DEFL:   prdata = {17'd0, maxdeg_q};
			default:        prdata = '0;
		endcase
	end

	assign lim_prod = maxdeg_q * DEG_TO_Q14 + DEG_RND;
	assign lim_raw  = lim_prod[39:24];

	always_ff @(posedge clk) begin
		lim_q <= (lim_raw > ANGLE_MAX) ? ANGLE_MAX[14:0] : lim_raw[14:0];
	end

	// ---------------- stall control ----------------
	logic [1:0]  cnt_q;
	logic        en;
	assign en = (cnt_q != 2'd2);
	assign s_axis_tready = en;

	// ---------------- S1: squares ----------------
	fdg_ctx_t    ctx_in;
	logic [63:0] sqx, sqy, sqz;
	logic        v_s1;
	fdg_ctx_t    ctx_s1;
	logic [63:0] sqx_s1, sqy_s1, sqz_s1;

	always_comb begin
		ctx_in.ax    = s_axis_tdata[31:0];
		ctx_in.ay    = s_axis_tdata[63:32];
		ctx_in.az    = s_axis_tdata[95:64];
		ctx_in.vx    = s_axis_tdata[127:96];
		ctx_in.vy    = s_axis_tdata[159:128];
		ctx_in.vz    = s_axis_tdata[191:160];
		ctx_in.q     = s_axis_tdata[223:192];
		ctx_in.vert  = 1'b0;
		ctx_in.inact = 1'b0;
	end

	assign sqx = mag32(ctx_in.vx) * mag32(ctx_in.vx);
	assign sqy = mag32(ctx_in.vy) * mag32(ctx_in.vy);
	assign sqz = mag32(ctx_in.vz) * mag32(ctx_in.vz);

	// ---------------- S2: sums ----------------
	logic        v_s2;
	fdg_ctx_t    ctx_s2;
	logic [63:0] h2_s2, s2_s2, yz_s2;

	// ---------------- S3: mode decisions ----------------
	logic [70:0] h2x100;
	logic        vert, inact;
	fdg_ctx_t    ctx_mode;
	logic        v_s3;
	fdg_ctx_t    ctx_s3;
	logic [63:0] sq_in_s3 [2];

	assign h2x100 = {1'b0, h2_s2, 6'd0} + {2'b0, h2_s2, 5'd0} + {5'b0, h2_s2, 2'd0};
	assign vert   = h2x100 < {7'd0, s2_s2};
	assign inact  = (s2_s2 < SPEED_MIN_SQ) || (ctx_s2.q < PRESS_MIN);

	always_comb begin
		ctx_mode       = ctx_s2;
		ctx_mode.vert  = vert;
		ctx_mode.inact = inact;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1      <= ctx_in;
			sqx_s1      <= sqx;
			sqy_s1      <= sqy;
			sqz_s1      <= sqz;
			ctx_s2      <= ctx_s1;
			h2_s2       <= sqx_s1 + sqy_s1;
			s2_s2       <= sqx_s1 + sqy_s1 + sqz_s1;
			yz_s2       <= sqy_s1 + sqz_s1;
			ctx_s3      <= ctx_mode;
			// lane 0: g or h, lane 1: s
			sq_in_s3[0] <= vert ? yz_s2 : h2_s2;
			sq_in_s3[1] <= s2_s2;
		end
	end

	// ---------------- square roots ----------------
	logic        sq_v;
	logic [31:0] sq_root [2];
	fdg_ctx_t    sq_ctx;

	fdg_isqrt #(
		.LANES (2),
		.SW    ($bits(fdg_ctx_t))
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_x      (sq_in_s3),
		.in_side   (ctx_s3),
		.out_valid (sq_v),
		.out_root  (sq_root),
		.out_side  (sq_ctx)
	);

	// ---------------- S4: divider operands ----------------
	// vertical: -vz/g, vy/g; otherwise vy/h, -vx/h, vz/s, h/s
	logic [31:0] dn [4];
	logic [31:0] dd [4];
	logic        v_s4;
	fdg_ctx_t    ctx_s4;
	logic [61:0] num_s4 [4];
	logic [31:0] den_s4 [4];

	always_comb begin
		dn[0] = sq_ctx.vert ? mag32(sq_ctx.vz) : mag32(sq_ctx.vy);
		dn[1] = sq_ctx.vert ? mag32(sq_ctx.vy) : mag32(sq_ctx.vx);
		dn[2] = mag32(sq_ctx.vz);
		dn[3] = sq_root[0];
		dd[0] = sq_root[0];
		dd[1] = sq_root[0];
		dd[2] = sq_root[1];
		dd[3] = sq_root[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v;
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_dop
		always_ff @(posedge clk) begin
			if (en) begin
				num_s4[i] <= {dn[i], 30'd0} + {31'd0, dd[i][31:1]};
				den_s4[i] <= dd[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= sq_ctx;
		end
	end

	// ---------------- axis divider ----------------
	logic                dv_v;
	logic [AXIS_QW-1:0]  dq [4];
	fdg_ctx_t            dctx;

	fdg_div #(
		.LANES (4),
		.NW    (62),
		.DW    (32),
		.QW    (AXIS_QW),
		.SW    ($bits(fdg_ctx_t))
	) u_axis_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_num    (num_s4),
		.in_den    (den_s4),
		.in_side   (ctx_s4),
		.out_valid (dv_v),
		.out_quo   (dq),
		.out_side  (dctx)
	);

	// ---------------- S5: Q30 products ----------------
	logic               v_s5;
	fdg_ctx_t           ctx_s5;
	logic [AXIS_QW-1:0] q_s5 [4];
	logic [61:0]        p02_s5, p12_s5;

	// ---------------- S6: signed axes ----------------
	logic               v_s6;
	fdg_ctx_t           ctx_s6;
	logic signed [31:0] px_s6, py_s6, pz_s6, rx_s6, ry_s6;
	logic [61:0]        pr02, pr12;
	logic signed [31:0] px_c, py_c, pz_c, rx_c, ry_c;
	logic               rx_neg, ry_neg, dz_neg;

	assign pr02   = p02_s5 + Q30_RND;
	assign pr12   = p12_s5 + Q30_RND;
	assign rx_neg = ctx_s5.vy[31];
	assign ry_neg = (ctx_s5.vx > 0);
	assign dz_neg = ctx_s5.vz[31];

	always_comb begin
		if (ctx_s5.vert) begin
			rx_c = ONE_Q30;
			ry_c = '0;
			px_c = '0;
			py_c = sgn31(ctx_s5.vz > 0, q_s5[0]);
			pz_c = sgn31(ctx_s5.vy[31], q_s5[1]);
		end else begin
			rx_c = sgn31(rx_neg, q_s5[0]);
			ry_c = sgn31(ry_neg, q_s5[1]);
			px_c = sgn31(ry_neg ^ dz_neg, pr12[60:30]);
			py_c = sgn31(!(rx_neg ^ dz_neg), pr02[60:30]);
			pz_c = sgn31(1'b0, q_s5[3]);
		end
	end

	// ---------------- S7: projection products ----------------
	logic               v_s7;
	fdg_ctx_t           ctx_s7;
	logic signed [63:0] m_s7 [5];

	// ---------------- S8: projection sums, lift product ----------------
	logic               v_s8;
	fdg_ctx_t           ctx_s8;
	logic signed [63:0] pp_s8, pw_s8;
	logic [47:0]        qs_s8;

	// ---------------- S9: scaled magnitudes ----------------
	logic               v_s9;
	logic               inact_s9;
	logic [47:0]        qs_s9;
	logic [60:0]        mp_s9, mw_s9;
	logic               negp_s9, negw_s9;
	logic [63:0]        magp, magw;

	assign magp = pp_s8[63] ? 64'(-pp_s8) : 64'(pp_s8);
	assign magw = pw_s8[63] ? 64'(-pw_s8) : 64'(pw_s8);

	// ---------------- S10: range checks ----------------
	logic               v_s10;
	fdg_fin_t           fin_s10;
	logic [60:0]        an_s10 [2];
	logic [47:0]        ad_s10 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s5  <= dv_v;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5  <= dctx;
			q_s5    <= dq;
			p02_s5  <= dq[0] * dq[2];
			p12_s5  <= dq[1] * dq[2];

			ctx_s6  <= ctx_s5;
			px_s6   <= px_c;
			py_s6   <= py_c;
			pz_s6   <= pz_c;
			rx_s6   <= rx_c;
			ry_s6   <= ry_c;

			ctx_s7  <= ctx_s6;
			m_s7[0] <= ctx_s6.ax * px_s6;
			m_s7[1] <= ctx_s6.ay * py_s6;
			m_s7[2] <= ctx_s6.az * pz_s6;
			m_s7[3] <= ctx_s6.ax * rx_s6;
			m_s7[4] <= ctx_s6.ay * ry_s6;

			ctx_s8  <= ctx_s7;
			pp_s8   <= m_s7[0] + m_s7[1] + m_s7[2];
			pw_s8   <= m_s7[3] + m_s7[4];
			qs_s8   <= slope_q * ctx_s7.q;

			inact_s9 <= ctx_s8.inact;
			qs_s9    <= qs_s8;
			mp_s9    <= magp[62:16] * ANGLE_SCALE;
			mw_s9    <= magw[62:16] * ANGLE_SCALE;
			negp_s9  <= pp_s8[63];
			negw_s9  <= pw_s8[63];

			// quotient at or above 2^15 always exceeds the limit
			fin_s10.ovf_p    <= {2'd0, mp_s9} >= {qs_s9, 15'd0};
			fin_s10.ovf_y    <= {2'd0, mw_s9} >= {qs_s9, 15'd0};
			fin_s10.neg_p    <= negp_s9;
			fin_s10.neg_y    <= negw_s9;
			fin_s10.lift_low <= qs_s9 <= LIFT_MIN;
			fin_s10.inact    <= inact_s9;
			an_s10[0]        <= mp_s9;
			an_s10[1]        <= mw_s9;
			ad_s10[0]        <= qs_s9;
			ad_s10[1]        <= qs_s9;
		end
	end

	// ---------------- angle divider ----------------
	logic               av_v;
	logic [ANG_QW-1:0]  aq [2];
	fdg_fin_t           afin;

	fdg_div #(
		.LANES (2),
		.NW    (61),
		.DW    (48),
		.QW    (ANG_QW),
		.SW    ($bits(fdg_fin_t))
	) u_angle_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s10),
		.in_num    (an_s10),
		.in_den    (ad_s10),
		.in_side   (fin_s10),
		.out_valid (av_v),
		.out_quo   (aq),
		.out_side  (afin)
	);

	// ---------------- clamp and sign ----------------
	logic [14:0]        ap, ay;
	logic signed [15:0] pitch, yaw;
	logic [32:0]        word;

	assign ap = (afin.ovf_p || aq[0] > lim_q) ? lim_q : aq[0];
	assign ay = (afin.ovf_y || aq[1] > lim_q) ? lim_q : aq[1];

	always_comb begin
		if (afin.lift_low || afin.inact) begin
			pitch = '0;
			yaw   = '0;
		end else begin
			pitch = afin.neg_p ? -signed'({1'b0, ap}) : signed'({1'b0, ap});
			yaw   = afin.neg_y ? -signed'({1'b0, ay}) : signed'({1'b0, ay});
		end
	end

	assign word = {afin.inact, yaw, pitch};

	// ---------------- output buffer ----------------
	logic [32:0] fifo_q [2];
	logic        wr_q, rd_q;
	logic        push, pop;

	assign push = en && av_v;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= word;
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = fifo_q[rd_q][31:0];
	assign m_axis_tuser  = fifo_q[rd_q][32];

	// ---------------- checks ----------------
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !s_axis_tready)
		else $error("input open while output buffer full");

	a_inact_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0))
		else $error("inactive word with nonzero angles");

	a_cnt_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("output buffer count lost a word");

endmodule
`default_nettype wire

### verif/testbench.sv
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fdg_pkg::*;

	typedef struct packed {
		logic [15:0] pitch;
		logic [15:0] yaw;
		logic        inact;
	} fin_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [223:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic m_axis_tuser;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	fin_deflection_from_guidance dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the registers
	logic [15:0] slope_q88 = LIFT_SLOPE_RST;
	logic [14:0] defl_q88 = MAX_DEFL_RST;

	fin_cmd_t expected_cmds[$];
	int send_idle_pct = 0, recv_idle_pct = 0;
	int mismatches = 0, words_in = 0, words_out = 0, inactive_seen = 0, vert_seen = 0;
	int quiet_cycles = 0;

	function automatic logic [63:0] mag(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unit_ratio(input longint v, input logic [63:0] d);
		logic [63:0] m;
		longint q;
		m = mag(v) << 30;
		q = longint'((m + d / 2) / d);
		return v < 0 ? -q : q;
	endfunction

	function automatic longint unit_mul(input longint a, input longint b);
		logic [63:0] m;
		longint q;
		m = mag(a) * mag(b);
		q = longint'((m + (64'd1 << 29)) >> 30);
		return ((a < 0) != (b < 0)) ? -q : q;
	endfunction

	function automatic longint fin_angle(input longint proj, input logic [63:0] qs,
			input longint lim);
		logic [63:0] a;
		longint r;
		a = ((mag(proj) >> 16) * 64'd10000) / qs;
		r = a > 64'(lim) ? lim : longint'(a);
		return proj < 0 ? -r : r;
	endfunction

	function automatic fin_cmd_t predict_fins(input logic [223:0] w);
		longint ax, ay, az, vx, vy, vz, rx, ry, px, py, pz, dz, lim, pitch, yaw;
		logic [63:0] q, mx, my, mz, h2, s2, g, h, s, lr, qs;
		fin_cmd_t c;
		ax = longint'($signed(w[31:0]));
		ay = longint'($signed(w[63:32]));
		az = longint'($signed(w[95:64]));
		vx = longint'($signed(w[127:96]));
		vy = longint'($signed(w[159:128]));
		vz = longint'($signed(w[191:160]));
		q = 64'(w[223:192]);
		mx = mag(vx); my = mag(vy); mz = mag(vz);
		h2 = mx * mx + my * my;
		s2 = h2 + mz * mz;
		c = '0;
		pitch = 0; yaw = 0;
		if (s2 < (64'd1 << 32) || q * 10 < 256) begin
			c.inact = 1'b1;
			return c;
		end
		if (h2 <= (s2 - 1) / 100) begin
			g = root_floor(my * my + mz * mz);
			rx = 64'sd1 << 30; ry = 0;
			px = 0;
			py = unit_ratio(-vz, g);
			pz = unit_ratio(vy, g);
		end else begin
			h = root_floor(h2);
			s = root_floor(s2);
			dz = unit_ratio(vz, s);
			rx = unit_ratio(vy, h);
			ry = unit_ratio(-vx, h);
			px = unit_mul(ry, dz);
			py = -unit_mul(rx, dz);
			pz = unit_ratio(longint'(h), s);
		end
		lr = (64'(defl_q88) * 64'd18740330 + (64'd1 << 23)) >> 24;
		lim = lr > 32767 ? 32767 : longint'(lr);
		qs = 64'(slope_q88) * q;
		if (qs > 6553600) begin
			pitch = fin_angle(ax * px + ay * py + az * pz, qs, lim);
			yaw = fin_angle(ax * rx + ay * ry, qs, lim);
		end
		c.pitch = pitch[15:0];
		c.yaw = yaw[15:0];
		return c;
	endfunction

	// output checker, receiver stalls, watchdog
	always @(posedge clk) begin
		fin_cmd_t got, want;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 20000) begin
				$display("watchdog: nothing moved, %0d results pending", expected_cmds.size());
				$display("Regression FAIL");
				$finish;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser};
				words_out <= words_out + 1;
				if (expected_cmds.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10) $display("unexpected word %h", got);
				end else begin
					want = expected_cmds.pop_front();
					if (got !== want) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("mismatch: exp pitch %h yaw %h inact %b, got %h %h %b",
								want.pitch, want.yaw, want.inact,
								got.pitch, got.yaw, got.inact);
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// valid stays high between back-to-back words; dropped only while idling
	task automatic send_word(input logic [223:0] w);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata <= w;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_cmds.push_back(predict_fins(w));
		if (predict_fins(w).inact) inactive_seen++;
		words_in++;
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [31:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {sel, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (sel == REG_LIFT_SLOPE) slope_q88 = v[15:0];
		else defl_q88 = v[14:0];
	endtask

	function automatic logic [223:0] pack_word(input logic [31:0] ax, ay, az, vx, vy, vz, q);
		return {q, vz, vy, vx, az, ay, ax};
	endfunction

	function automatic logic [31:0] rnd_comp();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			2: return 32'($signed($urandom_range(0, 60000000)) - 30000000);
			default: return 32'($signed($urandom_range(0, 200)) - 100);
		endcase
	endfunction

	task automatic test_directed;
		logic [31:0] mn, mx;
		mn = 32'h8000_0000; mx = 32'h7fff_ffff;
		send_word(pack_word(0, 0, 0, 0, 0, 0, 0));
		send_word(pack_word(mx, mx, mx, 32'h0000_ffff, 0, 0, 32'hffff_ffff));   // too slow
		send_word(pack_word(mx, mx, mx, 32'h0001_0000, 0, 0, 32'd25));          // thin air
		send_word(pack_word(mx, mx, mx, 32'h0001_0000, 0, 0, 32'd26));
		send_word(pack_word(mn, mn, mn, mn, mn, mn, 32'hffff_ffff));
		send_word(pack_word(mx, mx, mx, mx, mx, mx, 32'hffff_ffff));
		send_word(pack_word(mx, mn, mx, mn, mx, mn, 32'd6400));
		// near vertical, including exact vertical both ways
		send_word(pack_word(32'h0005_0000, 32'h0003_0000, 32'hfff0_0000, 0, 0, 32'h0064_0000,
			32'd100000));
		send_word(pack_word(mx, mn, mx, 0, 0, mn, 32'd100000));
		send_word(pack_word(32'h0100_0000, 32'h0100_0000, 0, 32'h0009_0000, 0,
			32'h0064_0000, 32'd200000));
		send_word(pack_word(32'h0100_0000, 32'h0100_0000, 0, 32'h000b_0000, 0,
			32'h0064_0000, 32'd200000));
		// weak lift boundary: slope 1024 * q = 6553600 -> q 6400
		send_word(pack_word(mx, mx, mx, 32'h0100_0000, 0, 0, 32'd6400));
		send_word(pack_word(mx, mx, mx, 32'h0100_0000, 0, 0, 32'd6401));
		send_word(pack_word(32'h0000_1000, mn, 32'h1, 32'h0100_0000, 32'h0100_0000, 0,
			32'h0010_0000));
		vert_seen += 3;
		drain();
	endtask

	task automatic test_random(input int n);
		logic [31:0] vx, vy, vz;
		repeat (n) begin
			vx = rnd_comp(); vy = rnd_comp(); vz = rnd_comp();
			if ($urandom_range(9) == 0) begin
				vx = $urandom_range(0, 65535) - 32768; vy = 32'($signed(vx) >>> 2);
				vert_seen++;
			end
			send_word(pack_word(rnd_comp(), rnd_comp(), rnd_comp(), vx, vy, vz,
				$urandom_range(3) == 0 ? $urandom : $urandom_range(0, 3000000)));
		end
		drain();
	endtask

	task automatic test_registers;
		write_reg(REG_LIFT_SLOPE, 32'd0);
		write_reg(REG_MAX_DEFL, 32'd0);
		test_random(20);
		write_reg(REG_LIFT_SLOPE, 32'd65535);
		write_reg(REG_MAX_DEFL, 32'd23040);
		test_random(30);
		write_reg(REG_LIFT_SLOPE, 32'd1);
		write_reg(REG_MAX_DEFL, 32'h7fff);
		test_random(30);
		write_reg(REG_LIFT_SLOPE, 32'd300);
		write_reg(REG_MAX_DEFL, 32'd1);
		test_random(30);
		write_reg(REG_LIFT_SLOPE, 32'd1024);
		write_reg(REG_MAX_DEFL, 32'd5120);
	endtask

	task automatic test_idle_mixes;
		send_idle_pct = 24; recv_idle_pct = 57;
		test_random(120);
		send_idle_pct = 57; recv_idle_pct = 24;
		test_random(110);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(110);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_registers();
		test_idle_mixes();
		$display("%0d words sent, %0d checked, %0d inactive, ~%0d near vertical,",
			words_in, words_out, inactive_seen, vert_seen);
		$display("registers swept through both extremes, then three stall mixes");
		if (mismatches == 0 && expected_cmds.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
src/fdg_pkg.sv
src/fdg_isqrt.sv
src/fdg_div.sv
src/fin_deflection_from_guidance.sv
verif/testbench.sv
